FILE: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mdt_pkg.sv
// ----------------------------------------------------------------------------
// mdt_pkg
// Types, codes and defaults for the two-pass city-block distance transform.
// ----------------------------------------------------------------------------
package mdt_pkg;

  localparam int DFLT_MAX_COLUMNS = 256;
  localparam int DFLT_MAX_ROWS    = 256;
  localparam int DFLT_DIST_BITS   = 10;

  localparam int CFG_BITS       = 9;
  localparam int CFG_INDEX_BITS = 1;
  localparam int DIM_RESET      = 256;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS    = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic operation;
    logic pixel;
  } mdt_in_t;

  typedef struct packed {
    logic [9:0] distance;
    logic [7:0] row_index;
    logic [7:0] column_index;
    logic       last;
  } mdt_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } mdt_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } mdt_cmd_t;

  typedef struct packed {
    logic gives_result;
    logic out_blocked;
  } mdt_status_t;

endpackage

FILE: src/mdt_ctrl.sv
// ----------------------------------------------------------------------------
// mdt_ctrl
// Sequencer: takes an item; commits it with buffered neighbours unless blocked.
// ----------------------------------------------------------------------------
module mdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdt_pkg::mdt_status_t status,
  output mdt_pkg::mdt_cmd_t    cmd
);

  mdt_pkg::mdt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mdt_pkg::ST_IDLE: begin
        if (in_valid) state_next = mdt_pkg::ST_EXEC;
      end
      mdt_pkg::ST_EXEC: begin
        if (!(status.gives_result && status.out_blocked)) state_next = mdt_pkg::ST_IDLE;
      end
      default: state_next = mdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      mdt_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      mdt_pkg::ST_EXEC: begin
        // hold while a result has nowhere to go
        cmd.commit = !(status.gives_result && status.out_blocked);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: src/mdt_datapath.sv
// ----------------------------------------------------------------------------
// mdt_datapath
// Frame memory, line buffers, neighbour registers, counters and output stage.
// ----------------------------------------------------------------------------
module mdt_datapath #(
  parameter int MAX_COLUMNS = mdt_pkg::DFLT_MAX_COLUMNS,
  parameter int MAX_ROWS    = mdt_pkg::DFLT_MAX_ROWS,
  parameter int DIST_BITS   = mdt_pkg::DFLT_DIST_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mdt_pkg::mdt_in_t                    in_item,
  input  logic                                cfg_write,
  input  logic [mdt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mdt_pkg::CFG_BITS-1:0]        cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mdt_pkg::mdt_out_t                   out_item,
  input  mdt_pkg::mdt_cmd_t                   cmd,
  output mdt_pkg::mdt_status_t                status
);

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DB    = mdt_pkg::CFG_BITS;
  localparam int DMAX  = (1 << DB) - 1;

  localparam logic [DB-1:0] COL_CAP = DB'((MAX_COLUMNS > DMAX) ? DMAX : MAX_COLUMNS);
  localparam logic [DB-1:0] ROW_CAP = DB'((MAX_ROWS > DMAX) ? DMAX : MAX_ROWS);
  localparam logic [DB-1:0] COL_RST =
    DB'((mdt_pkg::DIM_RESET > COL_CAP) ? COL_CAP : mdt_pkg::DIM_RESET);
  localparam logic [DB-1:0] ROW_RST =
    DB'((mdt_pkg::DIM_RESET > ROW_CAP) ? ROW_CAP : mdt_pkg::DIM_RESET);
  localparam logic [DIST_BITS-1:0] SENTINEL = '1;

  logic [DIST_BITS-1:0] frame_mem [CELLS];
  logic [DIST_BITS-1:0] above_mem [MAX_COLUMNS];
  logic [DIST_BITS-1:0] below_mem [MAX_COLUMNS];

  logic [DB-1:0]        cols, rows;
  logic [CW-1:0]        load_c, fetch_c;
  logic [RW-1:0]        load_r, fetch_r;
  logic                 full;
  logic [DIST_BITS-1:0] left_v, right_v;
  logic                 item_op, item_pix;
  logic [DIST_BITS-1:0] above_q, below_q, frame_q;

  logic [DB-1:0]        cols_m1, rows_m1, cfg_clamped, cfg_cap;
  logic [CW-1:0]        last_col;
  logic [RW-1:0]        last_row;
  logic [AW-1:0]        load_addr, fetch_addr;
  logic                 started, do_load, do_fetch, is_last;
  logic [DIST_BITS-1:0] fwd_v, bwd_v, inc_above, inc_left, inc_below, inc_right;
  logic [DIST_BITS+9:0] dist_wide;
  logic [RW+7:0]        row_wide;
  logic [CW+7:0]        col_wide;

  function automatic logic [DIST_BITS-1:0] inc_sat(input logic [DIST_BITS-1:0] v);
    inc_sat = (v == SENTINEL) ? SENTINEL : v + 1'b1;
  endfunction

  assign cols_m1  = cols - 1'b1;
  assign rows_m1  = rows - 1'b1;
  assign last_col = CW'(cols_m1);
  assign last_row = RW'(rows_m1);
  assign started  = full || (load_r != '0) || (load_c != '0);

  assign load_addr  = AW'(AW'(load_r) * AW'(MAX_COLUMNS) + AW'(load_c));
  assign fetch_addr = AW'(AW'(fetch_r) * AW'(MAX_COLUMNS) + AW'(fetch_c));

  // clamp a register write into 1..max
  always_comb begin
    cfg_cap     = (cfg_index == mdt_pkg::REG_COLUMNS) ? COL_CAP : ROW_CAP;
    cfg_clamped = cfg_data;
    if (cfg_data == '0) cfg_clamped = DB'(1);
    else if (cfg_data > cfg_cap) cfg_clamped = cfg_cap;
  end

  // forward pass value
  always_comb begin
    inc_above = inc_sat(above_q);
    inc_left  = inc_sat(left_v);
    fwd_v     = item_pix ? '0 : SENTINEL;
    if (load_r != '0 && inc_above < fwd_v) fwd_v = inc_above;
    if (load_c != '0 && inc_left < fwd_v) fwd_v = inc_left;
  end

  // backward pass value
  always_comb begin
    inc_below = inc_sat(below_q);
    inc_right = inc_sat(right_v);
    bwd_v     = frame_q;
    if (fetch_r != last_row && inc_below < bwd_v) bwd_v = inc_below;
    if (fetch_c != last_col && inc_right < bwd_v) bwd_v = inc_right;
  end

  assign do_load  = cmd.commit && (item_op == mdt_pkg::OP_LOAD) && !full;
  assign do_fetch = cmd.commit && (item_op == mdt_pkg::OP_FETCH) && full;
  assign is_last  = (fetch_r == '0) && (fetch_c == '0);

  assign status.gives_result = (item_op == mdt_pkg::OP_FETCH) && full;
  assign status.out_blocked  = out_valid && out_stall;

  assign dist_wide = {10'd0, bwd_v};
  assign row_wide  = {8'd0, fetch_r};
  assign col_wide  = {8'd0, fetch_c};

  // memories: read on capture, write on commit
  always_ff @(posedge clk) begin
    if (cmd.capture) frame_q <= frame_mem[fetch_addr];
    if (do_load) frame_mem[load_addr] <= fwd_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) above_q <= above_mem[load_c];
    if (do_load) above_mem[load_c] <= fwd_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) below_q <= below_mem[fetch_c];
    if (do_fetch) below_mem[fetch_c] <= bwd_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op  <= in_item.operation;
      item_pix <= in_item.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (do_fetch) begin
      out_item.distance     <= dist_wide[9:0];
      out_item.row_index    <= row_wide[7:0];
      out_item.column_index <= col_wide[7:0];
      out_item.last         <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols      <= COL_RST;
      rows      <= ROW_RST;
      load_r    <= '0;
      load_c    <= '0;
      fetch_r   <= '0;
      fetch_c   <= '0;
      full      <= 1'b0;
      left_v    <= SENTINEL;
      right_v   <= SENTINEL;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write && !started) begin
        if (cfg_index == mdt_pkg::REG_COLUMNS) cols <= cfg_clamped;
        else rows <= cfg_clamped;
      end

      if (out_valid && !out_stall && !do_fetch) out_valid <= 1'b0;

      if (do_load) begin
        left_v <= fwd_v;
        if (load_c == last_col) begin
          load_c <= '0;
          if (load_r == last_row) begin
            load_r  <= '0;
            full    <= 1'b1;
            fetch_r <= last_row;
            fetch_c <= last_col;
          end else begin
            load_r <= load_r + 1'b1;
          end
        end else begin
          load_c <= load_c + 1'b1;
        end
      end

      if (do_fetch) begin
        out_valid <= 1'b1;
        right_v   <= is_last ? SENTINEL : bwd_v;
        if (is_last) begin
          // frame done: reopen for loading
          full   <= 1'b0;
          left_v <= SENTINEL;
        end else if (fetch_c == '0) begin
          fetch_c <= last_col;
          fetch_r <= fetch_r - 1'b1;
        end else begin
          fetch_c <= fetch_c - 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/manhattan_distance_transform_top.sv
// ----------------------------------------------------------------------------
// manhattan_distance_transform_top
// Two-pass city-block distance transform over a frame held in memory.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    in_item  (operation, pixel)
//   out      from block out_valid / out_stall  out_item (distance, row, column, last)
//   cfg      to block   cfg_write              cfg_index, cfg_data
//
// Every item is taken in IDLE, which issues the registered reads of the frame
// memory and line buffers, and is combined and written back in EXEC.
// A fetch waits in EXEC only while an earlier result is stalled.
// Reset clears counters and neighbour registers; memories are not cleared.
// ----------------------------------------------------------------------------
module manhattan_distance_transform_top #(
  parameter int MAX_COLUMNS = mdt_pkg::DFLT_MAX_COLUMNS,
  parameter int MAX_ROWS    = mdt_pkg::DFLT_MAX_ROWS,
  parameter int DIST_BITS   = mdt_pkg::DFLT_DIST_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mdt_pkg::mdt_in_t                   in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mdt_pkg::mdt_out_t                  out_item,
  input  logic                               cfg_write,
  input  logic [mdt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mdt_pkg::CFG_BITS-1:0]       cfg_data
);

  mdt_pkg::mdt_cmd_t    cmd;
  mdt_pkg::mdt_status_t status;

  mdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mdt_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .DIST_BITS   (DIST_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: src/mdt_checker.sv
// ----------------------------------------------------------------------------
// mdt_checker
// Port-level checks on the distance transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdt_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mdt_pkg::mdt_out_t out_item
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "input taken on consecutive cycles")
  `ASSERT_IMPLIES(a_result_source, clk, rst, $rose(out_valid), $past(in_stall), "result without item in flight")
  `ASSERT_IMPLIES(a_last_origin, clk, rst, out_valid && out_item.last, out_item.row_index == 8'd0 && out_item.column_index == 8'd0, "last flag away from origin")

endmodule

bind manhattan_distance_transform_top mdt_checker u_mdt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: dv/tb_manhattan_distance_transform_top.sv
// ----------------------------------------------------------------------------
// tb_manhattan_distance_transform_top
// Self-checking bench for the city-block distance transform. A cycle-free
// predictor runs both passes on every accepted transfer. Each returned
// distance is compared field by field with the oldest predicted one. Frames
// of many shapes are loaded and fetched with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_manhattan_distance_transform_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF       = 5;
  localparam int          DBITS          = mdt_pkg::DFLT_DIST_BITS;
  localparam int unsigned MAX_COLS       = mdt_pkg::DFLT_MAX_COLUMNS;
  localparam int unsigned MAX_LINES      = mdt_pkg::DFLT_MAX_ROWS;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned RANDOM_ITEMS   = 300;
  localparam int unsigned MAX_SHOWN      = 30;
  localparam logic [DBITS-1:0] DIST_NONE = '1;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  mdt_pkg::mdt_in_t                   in_item   = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  mdt_pkg::mdt_out_t                  out_item;
  logic                               cfg_write = 1'b0;
  logic [mdt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [mdt_pkg::CFG_BITS-1:0]       cfg_data  = '0;

  manhattan_distance_transform_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Predictor state: both passes of the transform
  logic [DBITS-1:0] fwd_mem   [MAX_COLS*MAX_LINES];
  logic [DBITS-1:0] above_row [MAX_COLS];
  logic [DBITS-1:0] below_row [MAX_COLS];
  logic [DBITS-1:0] left_dist;
  logic [DBITS-1:0] right_dist;
  int unsigned      n_loaded;
  int unsigned      n_fetched;
  int unsigned      cols_cfg;
  int unsigned      rows_cfg;

  mdt_pkg::mdt_out_t pending_dist[$];
  int unsigned errors        = 0;
  int unsigned n_results     = 0;
  int unsigned n_loads_taken = 0;
  int unsigned n_ignored     = 0;
  int unsigned n_frames      = 0;
  int unsigned quiet_cycles  = 0;
  bit          steady        = 1'b0;
  bit          hold_req      = 1'b0;

  function automatic logic [DBITS-1:0] step_up(logic [DBITS-1:0] v);
    return (v == DIST_NONE) ? v : v + 1'b1;
  endfunction

  function automatic logic [DBITS-1:0] min_dist(logic [DBITS-1:0] a, logic [DBITS-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned clamp_dim(logic [mdt_pkg::CFG_BITS-1:0] v,
                                            int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void reset_transform();
    left_dist  = DIST_NONE;
    right_dist = DIST_NONE;
    n_loaded   = 0;
    n_fetched  = 0;
    cols_cfg   = clamp_dim(mdt_pkg::CFG_BITS'(mdt_pkg::DIM_RESET), MAX_COLS);
    rows_cfg   = clamp_dim(mdt_pkg::CFG_BITS'(mdt_pkg::DIM_RESET), MAX_LINES);
  endfunction

  function automatic void apply_reg_write(logic [mdt_pkg::CFG_INDEX_BITS-1:0] idx,
                                          logic [mdt_pkg::CFG_BITS-1:0] val);
    // size is frozen once the frame has started
    if (n_loaded != 0) return;
    case (idx)
      mdt_pkg::REG_COLUMNS: cols_cfg = clamp_dim(val, MAX_COLS);
      mdt_pkg::REG_ROWS:    rows_cfg = clamp_dim(val, MAX_LINES);
      default: ;
    endcase
  endfunction

  function automatic bit predict_distance(input mdt_pkg::mdt_in_t item,
                                          output mdt_pkg::mdt_out_t res);
    int unsigned      total;
    int unsigned      r;
    int unsigned      c;
    int unsigned      idx;
    logic [DBITS-1:0] v;
    total = cols_cfg * rows_cfg;
    res   = '0;
    if (item.operation == mdt_pkg::OP_LOAD) begin
      if (n_loaded >= total) begin
        n_ignored++;
        return 1'b0;
      end
      r = n_loaded / cols_cfg;
      c = n_loaded % cols_cfg;
      v = item.pixel ? '0 : DIST_NONE;
      if (r > 0) v = min_dist(v, step_up(above_row[c]));
      if (c > 0) v = min_dist(v, step_up(left_dist));
      fwd_mem[r*MAX_COLS + c] = v;
      above_row[c] = v;
      left_dist    = v;
      n_loaded++;
      n_loads_taken++;
      return 1'b0;
    end
    if (n_loaded < total || n_fetched >= total) begin
      n_ignored++;
      return 1'b0;
    end
    idx = total - 1 - n_fetched;
    r   = idx / cols_cfg;
    c   = idx % cols_cfg;
    v   = fwd_mem[r*MAX_COLS + c];
    if (r + 1 < rows_cfg) v = min_dist(v, step_up(below_row[c]));
    if (c + 1 < cols_cfg) v = min_dist(v, step_up(right_dist));
    below_row[c] = v;
    right_dist   = v;
    n_fetched++;
    res.distance     = v;
    res.row_index    = r[7:0];
    res.column_index = c[7:0];
    res.last         = (idx == 0);
    // frame done: rearm for the next load
    if (n_fetched >= total) begin
      n_loaded   = 0;
      n_fetched  = 0;
      left_dist  = DIST_NONE;
      right_dist = DIST_NONE;
      n_frames++;
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : scoreboard
    mdt_pkg::mdt_out_t want;
    mdt_pkg::mdt_out_t fresh;
    if (!rst) begin
      if (cfg_write) apply_reg_write(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (pending_dist.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: result with none expected: expected nothing, actual %p",
                     $time, out_item);
        end else begin
          want = pending_dist.pop_front();
          n_results++;
          if (out_item.distance !== want.distance)
            flag_mismatch("distance", want.distance, out_item.distance);
          if (out_item.row_index !== want.row_index)
            flag_mismatch("row_index", want.row_index, out_item.row_index);
          if (out_item.column_index !== want.column_index)
            flag_mismatch("column_index", want.column_index, out_item.column_index);
          if (out_item.last !== want.last)
            flag_mismatch("last", want.last, out_item.last);
        end
      end
      if (in_valid && !in_stall)
        if (predict_distance(in_item, fresh)) pending_dist = {pending_dist, fresh};
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, or one long hold-off on request
  always begin : stall_gen
    int unsigned n;
    @(negedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else begin
      n = (steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      out_stall <= (n != 0);
      if (n > 1) repeat (n - 1) @(negedge clk);
      if (n != 0) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic op, input logic pix);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= '{operation: op, pixel: pix};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    // loads give no result, so let the pipeline settle
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mdt_pkg::CFG_INDEX_BITS-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= mdt_pkg::CFG_BITS'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_frame(input int unsigned pct_set, input bit noise, input bit poke);
    int unsigned total;
    total = cols_cfg * rows_cfg;
    for (int unsigned k = 0; k < total; k++) begin
      if (noise && $urandom_range(0, 99) < 4)
        send_item(mdt_pkg::OP_FETCH, $urandom_range(0, 1));
      send_item(mdt_pkg::OP_LOAD, $urandom_range(0, 99) < pct_set);
      if (poke && k == total / 2) begin
        drain();
        write_reg(mdt_pkg::CFG_INDEX_BITS'($urandom_range(0, 1)), $urandom_range(0, 511));
      end
    end
    if (noise && $urandom_range(0, 99) < 30)
      send_item(mdt_pkg::OP_LOAD, $urandom_range(0, 1));
  endtask

  task automatic fetch_frame(input bit noise);
    int unsigned total;
    total = cols_cfg * rows_cfg;
    for (int unsigned k = 0; k < total; k++) begin
      if (noise && $urandom_range(0, 99) < 3)
        send_item(mdt_pkg::OP_LOAD, $urandom_range(0, 1));
      send_item(mdt_pkg::OP_FETCH, $urandom_range(0, 1));
    end
  endtask

  task automatic test_early_fetch();
    send_item(mdt_pkg::OP_FETCH, 1'b0);
    send_item(mdt_pkg::OP_FETCH, 1'b1);
    drain();
  endtask

  task automatic test_single_cell();
    write_reg(mdt_pkg::REG_COLUMNS, 0);
    write_reg(mdt_pkg::REG_ROWS, 0);
    send_item(mdt_pkg::OP_LOAD, 1'b1);
    send_item(mdt_pkg::OP_FETCH, 1'b0);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    send_item(mdt_pkg::OP_FETCH, 1'b1);
    drain();
  endtask

  task automatic test_small_frame();
    write_reg(mdt_pkg::REG_COLUMNS, 3);
    write_reg(mdt_pkg::REG_ROWS, 2);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    drain();
    // frame already started: this write must not take
    write_reg(mdt_pkg::REG_COLUMNS, 5);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    send_item(mdt_pkg::OP_LOAD, 1'b1);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    send_item(mdt_pkg::OP_LOAD, 1'b1);
    for (int k = 0; k < 6; k++) send_item(mdt_pkg::OP_FETCH, k[0]);
    drain();
  endtask

  task automatic test_empty_frame();
    write_reg(mdt_pkg::REG_COLUMNS, 2);
    write_reg(mdt_pkg::REG_ROWS, 1);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    send_item(mdt_pkg::OP_LOAD, 1'b0);
    send_item(mdt_pkg::OP_FETCH, 1'b0);
    send_item(mdt_pkg::OP_FETCH, 1'b1);
    drain();
  endtask

  task automatic test_extreme_sizes();
    // oversized width clamps to the full line
    write_reg(mdt_pkg::REG_COLUMNS, 511);
    write_reg(mdt_pkg::REG_ROWS, 1);
    load_frame(3, 1'b0, 1'b0);
    fetch_frame(1'b0);
    drain();
  endtask

  task automatic test_back_pressure();
    write_reg(mdt_pkg::REG_COLUMNS, 4);
    write_reg(mdt_pkg::REG_ROWS, 6);
    load_frame(30, 1'b0, 1'b0);
    steady   = 1'b1;
    hold_req = 1'b1;
    fetch_frame(1'b0);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned base;
    int unsigned cols;
    int unsigned lines;
    int unsigned pct;
    base = n_loads_taken + n_results;
    while (n_loads_taken + n_results - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          cols  = $urandom_range(17, 64);
          lines = $urandom_range(1, 2);
        end
        1: begin
          cols  = $urandom_range(1, 2);
          lines = $urandom_range(17, 64);
        end
        default: begin
          cols  = $urandom_range(1, 12);
          lines = $urandom_range(1, 12);
        end
      endcase
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 2;
        2:       pct = 10;
        3:       pct = 40;
        default: pct = 95;
      endcase
      // sometimes keep one dimension from the previous frame
      if ($urandom_range(0, 4) != 0) write_reg(mdt_pkg::REG_COLUMNS, cols);
      if ($urandom_range(0, 4) != 0) write_reg(mdt_pkg::REG_ROWS, lines);
      steady = ($urandom_range(0, 4) == 0);
      load_frame(pct, 1'b1, $urandom_range(0, 9) == 0);
      fetch_frame(1'b1);
      drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    reset_transform();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_early_fetch();
    test_single_cell();
    test_small_frame();
    test_empty_frame();
    test_extreme_sizes();
    test_back_pressure();
    test_random_frames();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d frames: %0d pixels loaded, %0d distances checked, %0d transfers ignored.",
             n_frames, n_loads_taken, n_results, n_ignored);
    $display("Shapes from 1x1 up to a full 256-wide line, random gaps and one long output hold.");
    if (pending_dist.size() != 0)
      $display("%0t: %0d predicted distances never arrived", $time, pending_dist.size());
    if (errors == 0 && pending_dist.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/mdt_pkg.sv
src/mdt_ctrl.sv
src/mdt_datapath.sv
src/manhattan_distance_transform_top.sv
src/mdt_checker.sv
dv/tb_manhattan_distance_transform_top.sv
